>>> hdl/hsps_pkg.sv
// ----------------------------------------------------------------------------
// hsps_pkg
// Shared codes, types and syntax tables of the SPS header parser.
// ----------------------------------------------------------------------------
package hsps_pkg;

  localparam int GOLOMB_MAX_BITS = 32;

  localparam logic [5:0] S_PROFILE      = 6'd0;
  localparam logic [5:0] S_CONSTRAINT   = 6'd1;
  localparam logic [5:0] S_LEVEL        = 6'd2;
  localparam logic [5:0] S_SPS_ID       = 6'd3;
  localparam logic [5:0] S_CHROMA       = 6'd4;
  localparam logic [5:0] S_SEP_PLANE    = 6'd5;
  localparam logic [5:0] S_DEPTH_LUMA   = 6'd6;
  localparam logic [5:0] S_DEPTH_CHROMA = 6'd7;
  localparam logic [5:0] S_BYPASS       = 6'd8;
  localparam logic [5:0] S_MATRIX_FLAG  = 6'd9;
  localparam logic [5:0] S_LIST_FLAG    = 6'd10;
  localparam logic [5:0] S_LIST_DELTA   = 6'd11;
  localparam logic [5:0] S_FRAME_NUM    = 6'd12;
  localparam logic [5:0] S_POC_TYPE     = 6'd13;
  localparam logic [5:0] S_POC_LSB      = 6'd14;
  localparam logic [5:0] S_DELTA_ZERO   = 6'd15;
  localparam logic [5:0] S_OFF_NONREF   = 6'd16;
  localparam logic [5:0] S_OFF_TB       = 6'd17;
  localparam logic [5:0] S_CYCLE_N      = 6'd18;
  localparam logic [5:0] S_CYCLE_OFF    = 6'd19;
  localparam logic [5:0] S_NUM_REF      = 6'd20;
  localparam logic [5:0] S_GAPS         = 6'd21;
  localparam logic [5:0] S_WIDTH        = 6'd22;
  localparam logic [5:0] S_HEIGHT       = 6'd23;
  localparam logic [5:0] S_FRAME_ONLY   = 6'd24;
  localparam logic [5:0] S_MBAFF        = 6'd25;
  localparam logic [5:0] S_DIRECT       = 6'd26;
  localparam logic [5:0] S_CROP_FLAG    = 6'd27;
  localparam logic [5:0] S_CROP         = 6'd28;
  localparam logic [5:0] S_VUI          = 6'd29;
  localparam logic [5:0] S_AR_FLAG      = 6'd30;
  localparam logic [5:0] S_AR_IDC       = 6'd31;
  localparam logic [5:0] S_SAR_W        = 6'd32;
  localparam logic [5:0] S_SAR_H        = 6'd33;
  localparam logic [5:0] S_OVERSCAN     = 6'd34;
  localparam logic [5:0] S_OVERSCAN_APP = 6'd35;
  localparam logic [5:0] S_VIDEO_SIG    = 6'd36;
  localparam logic [5:0] S_VIDEO_FMT    = 6'd37;
  localparam logic [5:0] S_FULL_RANGE   = 6'd38;
  localparam logic [5:0] S_COLOUR_DESC  = 6'd39;
  localparam logic [5:0] S_PRIMARIES    = 6'd40;
  localparam logic [5:0] S_TRANSFER     = 6'd41;
  localparam logic [5:0] S_MATRIX       = 6'd42;
  localparam logic [5:0] S_CHROMA_LOC   = 6'd43;
  localparam logic [5:0] S_LOC_TOP      = 6'd44;
  localparam logic [5:0] S_LOC_BOT      = 6'd45;
  localparam logic [5:0] S_TIMING       = 6'd46;
  localparam logic [5:0] S_TICK         = 6'd47;
  localparam logic [5:0] S_SCALE        = 6'd48;
  localparam logic [5:0] S_FIXED        = 6'd49;
  localparam logic [5:0] S_DONE         = 6'd50;
  localparam logic [5:0] S_ERROR        = 6'd51;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_TIMING = 2'd1;
  localparam logic [1:0] STATUS_BAD       = 2'd2;

  typedef struct packed {
    logic       load;
    logic       bit_en;
    logic [2:0] bit_sel;
    logic       calc;
    logic       emit;
  } hsps_cmd_t;

  typedef struct packed {
    logic [4:0]  set_id;
    logic [7:0]  profile;
    logic [7:0]  level;
    logic [1:0]  chroma_format;
    logic        frame_only;
    logic [1:0]  order_count_type;
    logic [3:0]  frame_num_bits_minus4;
    logic [15:0] picture_width;
    logic [15:0] picture_height;
    logic [31:0] rate_numerator;
    logic [32:0] rate_denominator;
    logic [1:0]  status;
  } hsps_result_t;

  // bit length of a fixed field, 0 for Exp-Golomb fields
  function automatic logic [5:0] field_len(input logic [5:0] step);
    logic [5:0] len;
    len = 6'd0;
    unique case (step)
      S_PROFILE, S_CONSTRAINT, S_LEVEL, S_AR_IDC,
      S_PRIMARIES, S_TRANSFER, S_MATRIX:           len = 6'd8;
      S_SAR_W, S_SAR_H:                            len = 6'd16;
      S_TICK, S_SCALE:                             len = 6'd32;
      S_VIDEO_FMT:                                 len = 6'd3;
      S_SEP_PLANE, S_BYPASS, S_MATRIX_FLAG, S_LIST_FLAG, S_DELTA_ZERO,
      S_GAPS, S_FRAME_ONLY, S_MBAFF, S_DIRECT, S_CROP_FLAG, S_VUI,
      S_AR_FLAG, S_OVERSCAN, S_OVERSCAN_APP, S_VIDEO_SIG, S_FULL_RANGE,
      S_COLOUR_DESC, S_CHROMA_LOC, S_TIMING, S_FIXED: len = 6'd1;
      default:                                     len = 6'd0;
    endcase
    return len;
  endfunction

  function automatic logic field_se(input logic [5:0] step);
    return (step == S_LIST_DELTA) || (step == S_OFF_NONREF) ||
           (step == S_OFF_TB) || (step == S_CYCLE_OFF);
  endfunction

endpackage

>>> hdl/hsps_in_if.sv
// ----------------------------------------------------------------------------
// hsps_in_if
// Byte channel into the SPS header parser.
// ----------------------------------------------------------------------------
interface hsps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

>>> hdl/hsps_out_if.sv
// ----------------------------------------------------------------------------
// hsps_out_if
// Result channel out of the SPS header parser.
// ----------------------------------------------------------------------------
interface hsps_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  set_id;
  logic [7:0]  profile;
  logic [7:0]  level;
  logic [1:0]  chroma_format;
  logic        frame_only;
  logic [1:0]  order_count_type;
  logic [3:0]  frame_num_bits_minus4;
  logic [15:0] picture_width;
  logic [15:0] picture_height;
  logic [31:0] rate_numerator;
  logic [32:0] rate_denominator;
  logic [1:0]  status;

  modport source (output valid, set_id, profile, level, chroma_format, frame_only,
                  order_count_type, frame_num_bits_minus4, picture_width,
                  picture_height, rate_numerator, rate_denominator, status,
                  input ready);
  modport sink (input valid, set_id, profile, level, chroma_format, frame_only,
                order_count_type, frame_num_bits_minus4, picture_width,
                picture_height, rate_numerator, rate_denominator, status,
                output ready);
endinterface

>>> hdl/hsps_rate.sv
// ----------------------------------------------------------------------------
// hsps_rate
// Frame rate reduction: binary gcd one step a cycle, then a restoring
// division of numerator and denominator by the gcd, one bit a cycle.
// ----------------------------------------------------------------------------
module hsps_rate
  import hsps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] num,
  input  logic [32:0] den,
  output logic        done,
  output logic [31:0] quot_num,
  output logic [32:0] quot_den
);

  localparam logic [1:0] RS_IDLE = 2'd0;
  localparam logic [1:0] RS_GCD  = 2'd1;
  localparam logic [1:0] RS_DIV  = 2'd2;
  localparam logic [1:0] RS_DONE = 2'd3;

  logic [1:0]  state;
  logic [32:0] a, b, g, nsh, dsh, rn, rd;
  logic [5:0]  k, cnt;
  logic [32:0] gval;
  logic [33:0] rn_sh, rd_sh;
  logic        qn, qd;

  assign gval  = ((a == 33'd0) ? b : a) << k;
  assign rn_sh = {rn, nsh[32]};
  assign rd_sh = {rd, dsh[32]};
  assign qn    = rn_sh >= {1'b0, g};
  assign qd    = rd_sh >= {1'b0, g};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RS_IDLE;
      cnt   <= 6'd0;
    end else if (start) begin
      state <= RS_GCD;
      a     <= num;
      b     <= den;
      nsh   <= num;
      dsh   <= den;
      k     <= 6'd0;
    end else begin
      unique case (state)
        RS_GCD: begin
          if (a == 33'd0 || b == 33'd0) begin
            g   <= gval;
            rn  <= 33'd0;
            rd  <= 33'd0;
            cnt <= 6'd0;
            if (gval == 33'd0) begin
              nsh   <= 33'd0;
              dsh   <= 33'd0;
              state <= RS_DONE;
            end else begin
              state <= RS_DIV;
            end
          end else if (!a[0] && !b[0]) begin
            a <= a >> 1;
            b <= b >> 1;
            k <= k + 6'd1;
          end else if (!a[0]) begin
            a <= a >> 1;
          end else if (!b[0]) begin
            b <= b >> 1;
          end else if (a >= b) begin
            a <= a - b;
          end else begin
            b <= b - a;
          end
        end
        RS_DIV: begin
          rn  <= qn ? 33'(rn_sh - {1'b0, g}) : rn_sh[32:0];
          rd  <= qd ? 33'(rd_sh - {1'b0, g}) : rd_sh[32:0];
          nsh <= {nsh[31:0], qn};
          dsh <= {dsh[31:0], qd};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd32) state <= RS_DONE;
        end
        default: ;
      endcase
    end
  end

  assign done     = state == RS_DONE;
  assign quot_num = nsh[31:0];
  assign quot_den = dsh;

endmodule

>>> hdl/hsps_datapath.sv
// ----------------------------------------------------------------------------
// hsps_datapath
// Bit-serial syntax engine, parsed field store and result assembly.
// ----------------------------------------------------------------------------
module hsps_datapath
  import hsps_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  hsps_cmd_t    cmd,
  input  logic [7:0]   data_byte,
  input  logic [31:0]  quot_num,
  input  logic [32:0]  quot_den,
  output logic [32:0]  rate_num,
  output logic [32:0]  rate_den,
  output hsps_result_t result
);

  logic [7:0]  byte_reg;
  logic [31:0] window, window_next;
  logic [5:0]  avail, avail_next;
  logic [5:0]  step, step_next;
  logic [5:0]  zc, zc_next;
  logic [7:0]  loop_cnt, loop_cnt_next;
  logic [3:0]  list_idx, list_idx_next;
  logic [7:0]  prev_scale, prev_scale_next;
  logic [31:0] crop [4];
  logic [31:0] crop_val;
  logic        crop_we;
  logic [7:0]  profile, profile_next, level, level_next;
  logic [4:0]  set_id, set_id_next;
  logic [1:0]  chroma, chroma_next;
  logic        fo, fo_next, crop_flag, crop_flag_next, timing, timing_next;
  logic [1:0]  poc, poc_next;
  logic [3:0]  fnb, fnb_next;
  logic [31:0] wm1, wm1_next, hm1, hm1_next, tick, tick_next, tscale, tscale_next;

  logic        b, deliver;
  logic [5:0]  len;
  logic [31:0] code, value, win_shift;
  logic [32:0] code_inc;
  logic [7:0]  ns;
  logic [3:0]  li_inc;

  assign b         = byte_reg[cmd.bit_sel];
  assign len       = field_len(step);
  assign win_shift = {window[30:0], b};
  assign code_inc  = {1'b0, code} + 33'd1;
  assign value     = !field_se(step) ? code :
                     code[0] ? code_inc[32:1] : 32'(32'd0 - {1'b0, code[31:1]});
  assign ns        = prev_scale + value[7:0];
  assign li_inc    = list_idx + 4'd1;

  always_comb begin
    window_next     = window;
    avail_next      = avail;
    step_next       = step;
    zc_next         = zc;
    loop_cnt_next   = loop_cnt;
    list_idx_next   = list_idx;
    prev_scale_next = prev_scale;
    profile_next    = profile;
    level_next      = level;
    set_id_next     = set_id;
    chroma_next     = chroma;
    fo_next         = fo;
    crop_flag_next  = crop_flag;
    timing_next     = timing;
    poc_next        = poc;
    fnb_next        = fnb;
    wm1_next        = wm1;
    hm1_next        = hm1;
    tick_next       = tick;
    tscale_next     = tscale;
    crop_we         = 1'b0;
    crop_val        = value;
    deliver         = 1'b0;
    code            = 32'd0;
    if (cmd.bit_en && step < S_DONE) begin
      if (len != 6'd0) begin
        if ({1'b0, avail} + 7'd1 >= {1'b0, len}) begin
          deliver = 1'b1;
          code    = win_shift;
        end else begin
          window_next = win_shift;
          avail_next  = avail + 6'd1;
        end
      end else if (window == 32'd0) begin
        if (!b) begin
          zc_next = zc + 6'd1;
          if ({1'b0, zc} + 7'd1 >= 7'(GOLOMB_MAX_BITS)) step_next = S_ERROR;
        end else if (zc == 6'd0) begin
          deliver = 1'b1;
        end else begin
          window_next = 32'd1;
          avail_next  = 6'd0;
        end
      end else if ({1'b0, avail} + 7'd1 >= {1'b0, zc}) begin
        deliver = 1'b1;
        code    = win_shift - 32'd1;
      end else begin
        window_next = win_shift;
        avail_next  = avail + 6'd1;
      end
    end
    if (deliver) begin
      window_next = 32'd0;
      avail_next  = 6'd0;
      zc_next     = 6'd0;
      unique case (step)
        S_PROFILE: begin
          profile_next = value[7:0];
          chroma_next  = 2'd1;
          step_next    = S_CONSTRAINT;
        end
        S_CONSTRAINT: step_next = S_LEVEL;
        S_LEVEL: begin
          level_next = value[7:0];
          step_next  = S_SPS_ID;
        end
        S_SPS_ID: begin
          if (value > 32'd31) begin
            step_next = S_ERROR;
          end else begin
            set_id_next = value[4:0];
            step_next   = (profile == 8'd100 || profile == 8'd110 ||
                           profile == 8'd122 || profile == 8'd144) ? S_CHROMA : S_FRAME_NUM;
          end
        end
        S_CHROMA: begin
          if (value > 32'd3) begin
            step_next = S_ERROR;
          end else begin
            chroma_next = value[1:0];
            step_next   = (value == 32'd3) ? S_SEP_PLANE : S_DEPTH_LUMA;
          end
        end
        S_SEP_PLANE:    step_next = S_DEPTH_LUMA;
        S_DEPTH_LUMA:   step_next = S_DEPTH_CHROMA;
        S_DEPTH_CHROMA: step_next = S_BYPASS;
        S_BYPASS:       step_next = S_MATRIX_FLAG;
        S_MATRIX_FLAG: begin
          list_idx_next = 4'd0;
          step_next     = value[0] ? S_LIST_FLAG : S_FRAME_NUM;
        end
        S_LIST_FLAG: begin
          if (value[0]) begin
            loop_cnt_next   = 8'd0;
            prev_scale_next = 8'd8;
            step_next       = S_LIST_DELTA;
          end else begin
            list_idx_next = li_inc;
            step_next     = (li_inc >= 4'd8) ? S_FRAME_NUM : S_LIST_FLAG;
          end
        end
        S_LIST_DELTA: begin
          if (ns != 8'd0) prev_scale_next = ns;
          loop_cnt_next = loop_cnt + 8'd1;
          if (ns == 8'd0 ||
              loop_cnt + 8'd1 >= ((list_idx < 4'd6) ? 8'd16 : 8'd64)) begin
            list_idx_next = li_inc;
            step_next     = (li_inc >= 4'd8) ? S_FRAME_NUM : S_LIST_FLAG;
          end
        end
        S_FRAME_NUM: begin
          if (value > 32'd12) begin
            step_next = S_ERROR;
          end else begin
            fnb_next  = value[3:0];
            step_next = S_POC_TYPE;
          end
        end
        S_POC_TYPE: begin
          if (value > 32'd2) begin
            step_next = S_ERROR;
          end else begin
            poc_next  = value[1:0];
            step_next = (value == 32'd0) ? S_POC_LSB :
                        (value == 32'd1) ? S_DELTA_ZERO : S_NUM_REF;
          end
        end
        S_POC_LSB:    step_next = S_NUM_REF;
        S_DELTA_ZERO: step_next = S_OFF_NONREF;
        S_OFF_NONREF: step_next = S_OFF_TB;
        S_OFF_TB:     step_next = S_CYCLE_N;
        S_CYCLE_N: begin
          if (value > 32'd255) begin
            step_next = S_ERROR;
          end else begin
            loop_cnt_next = value[7:0];
            step_next     = (value != 32'd0) ? S_CYCLE_OFF : S_NUM_REF;
          end
        end
        S_CYCLE_OFF: begin
          if (loop_cnt > 8'd0) loop_cnt_next = loop_cnt - 8'd1;
          if (loop_cnt <= 8'd1) step_next = S_NUM_REF;
        end
        S_NUM_REF: step_next = S_GAPS;
        S_GAPS:    step_next = S_WIDTH;
        S_WIDTH: begin
          wm1_next  = value;
          step_next = S_HEIGHT;
        end
        S_HEIGHT: begin
          hm1_next  = value;
          step_next = S_FRAME_ONLY;
        end
        S_FRAME_ONLY: begin
          if (value[0]) fo_next = 1'b1;
          step_next = value[0] ? S_DIRECT : S_MBAFF;
        end
        S_MBAFF:  step_next = S_DIRECT;
        S_DIRECT: step_next = S_CROP_FLAG;
        S_CROP_FLAG: begin
          if (value[0]) begin
            crop_flag_next = 1'b1;
            loop_cnt_next  = 8'd0;
            step_next      = S_CROP;
          end else begin
            step_next = S_VUI;
          end
        end
        S_CROP: begin
          crop_we       = 1'b1;
          loop_cnt_next = loop_cnt + 8'd1;
          if (loop_cnt + 8'd1 >= 8'd4) step_next = S_VUI;
        end
        S_VUI:          step_next = value[0] ? S_AR_FLAG : S_DONE;
        S_AR_FLAG:      step_next = value[0] ? S_AR_IDC : S_OVERSCAN;
        S_AR_IDC:       step_next = (value == 32'd255) ? S_SAR_W : S_OVERSCAN;
        S_SAR_W:        step_next = S_SAR_H;
        S_SAR_H:        step_next = S_OVERSCAN;
        S_OVERSCAN:     step_next = value[0] ? S_OVERSCAN_APP : S_VIDEO_SIG;
        S_OVERSCAN_APP: step_next = S_VIDEO_SIG;
        S_VIDEO_SIG:    step_next = value[0] ? S_VIDEO_FMT : S_CHROMA_LOC;
        S_VIDEO_FMT:    step_next = S_FULL_RANGE;
        S_FULL_RANGE:   step_next = S_COLOUR_DESC;
        S_COLOUR_DESC:  step_next = value[0] ? S_PRIMARIES : S_CHROMA_LOC;
        S_PRIMARIES:    step_next = S_TRANSFER;
        S_TRANSFER:     step_next = S_MATRIX;
        S_MATRIX:       step_next = S_CHROMA_LOC;
        S_CHROMA_LOC:   step_next = value[0] ? S_LOC_TOP : S_TIMING;
        S_LOC_TOP:      step_next = S_LOC_BOT;
        S_LOC_BOT:      step_next = S_TIMING;
        S_TIMING: begin
          if (value[0]) timing_next = 1'b1;
          step_next = value[0] ? S_TICK : S_DONE;
        end
        S_TICK: begin
          tick_next = value;
          step_next = S_SCALE;
        end
        S_SCALE: begin
          tscale_next = value;
          step_next   = S_FIXED;
        end
        S_FIXED: step_next = S_DONE;
        default: step_next = S_ERROR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) byte_reg <= data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      window     <= 32'd0;
      avail      <= 6'd0;
      step       <= S_PROFILE;
      zc         <= 6'd0;
      loop_cnt   <= 8'd0;
      list_idx   <= 4'd0;
      prev_scale <= 8'd8;
      for (int i = 0; i < 4; i++) crop[i] <= 32'd0;
      profile    <= 8'd0;
      level      <= 8'd0;
      set_id     <= 5'd0;
      chroma     <= 2'd0;
      fo         <= 1'b0;
      crop_flag  <= 1'b0;
      timing     <= 1'b0;
      poc        <= 2'd0;
      fnb        <= 4'd0;
      wm1        <= 32'd0;
      hm1        <= 32'd0;
      tick       <= 32'd0;
      tscale     <= 32'd0;
    end else begin
      window     <= window_next;
      avail      <= avail_next;
      step       <= step_next;
      zc         <= zc_next;
      loop_cnt   <= loop_cnt_next;
      list_idx   <= list_idx_next;
      prev_scale <= prev_scale_next;
      if (crop_we) crop[loop_cnt[1:0]] <= crop_val;
      profile    <= profile_next;
      level      <= level_next;
      set_id     <= set_id_next;
      chroma     <= chroma_next;
      fo         <= fo_next;
      crop_flag  <= crop_flag_next;
      timing     <= timing_next;
      poc        <= poc_next;
      fnb        <= fnb_next;
      wm1        <= wm1_next;
      hm1        <= hm1_next;
      tick       <= tick_next;
      tscale     <= tscale_next;
    end
  end

  assign rate_num = {1'b0, tscale};
  assign rate_den = {tick, 1'b0};

  logic [37:0] w_base, h_base, cx, cy;
  logic [32:0] sum_x, sum_y;
  logic [32:0] hm1_inc, wm1_inc;
  logic [1:0]  calc_status;
  logic [1:0]  ysh;

  assign sum_x   = {1'b0, crop[0]} + {1'b0, crop[1]};
  assign sum_y   = {1'b0, crop[2]} + {1'b0, crop[3]};
  assign wm1_inc = {1'b0, wm1} + 33'd1;
  assign hm1_inc = {1'b0, hm1} + 33'd1;
  assign ysh     = {1'b0, chroma == 2'd1} + {1'b0, !fo};

  function automatic logic [15:0] clamp16(input logic [37:0] base, input logic [37:0] sub);
    logic [37:0] diff;
    diff = base - sub;
    if (sub > base) return 16'd0;
    if (diff > 38'd65535) return 16'hffff;
    return diff[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      w_base <= {1'b0, wm1_inc, 4'd0};
      h_base <= fo ? {1'b0, hm1_inc, 4'd0} : {hm1_inc, 5'd0};
      cx     <= !crop_flag ? 38'd0 :
                (chroma == 2'd1 || chroma == 2'd2) ? {4'd0, sum_x, 1'b0} : {5'd0, sum_x};
      cy     <= !crop_flag ? 38'd0 : {5'd0, sum_y} << ysh;
      calc_status <= (step != S_DONE) ? STATUS_BAD : timing ? STATUS_OK : STATUS_NO_TIMING;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (calc_status == STATUS_BAD) begin
        result <= hsps_result_t'(STATUS_BAD);
      end else begin
        result.set_id                <= set_id;
        result.profile               <= profile;
        result.level                 <= level;
        result.chroma_format         <= chroma;
        result.frame_only            <= fo;
        result.order_count_type      <= poc;
        result.frame_num_bits_minus4 <= fnb;
        result.picture_width         <= clamp16(w_base, cx);
        result.picture_height        <= clamp16(h_base, cy);
        result.rate_numerator        <= (calc_status == STATUS_OK) ? quot_num : 32'd0;
        result.rate_denominator      <= (calc_status == STATUS_OK) ? quot_den : 33'd0;
        result.status                <= calc_status;
      end
    end
  end

endmodule

>>> hdl/hsps_ctrl.sv
// ----------------------------------------------------------------------------
// hsps_ctrl
// Sequencer: byte intake, eight bit steps per byte, result calculation,
// rate reduction wait and result register handoff.
// ----------------------------------------------------------------------------
module hsps_ctrl
  import hsps_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  logic      rate_done,
  output logic      rate_start,
  output hsps_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BITS = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_RATE = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state, state_next;
  logic [2:0] cnt;
  logic       last;
  logic       in_accept;

  assign in_ready   = state == ST_IDLE;
  assign in_accept  = in_valid && in_ready;
  assign rate_start = state == ST_CALC;

  always_comb begin
    cmd         = '0;
    cmd.load    = in_accept;
    cmd.bit_en  = state == ST_BITS;
    cmd.bit_sel = 3'd7 - cnt;
    cmd.calc    = state == ST_CALC;
    cmd.emit    = (state == ST_EMIT) && (!out_valid || out_ready);
    state_next  = state;
    unique case (state)
      ST_IDLE: if (in_accept) state_next = ST_BITS;
      ST_BITS: if (cnt == 3'd7) state_next = last ? ST_CALC : ST_IDLE;
      ST_CALC: state_next = ST_RATE;
      ST_RATE: if (rate_done) state_next = ST_EMIT;
      ST_EMIT: if (cmd.emit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= 3'd0;
      last      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_accept) begin
        last <= in_last;
        cnt  <= 3'd0;
      end else if (state == ST_BITS) begin
        cnt <= cnt + 3'd1;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready)) else $error("result register overwritten");

  a_no_intake_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.bit_en |-> !in_ready) else $error("byte taken while bits are shifting");

  a_last_to_calc: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_last) |-> ##9 (state == ST_CALC)) else $error("last byte not finished");

  a_emit_after_rate: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> rate_done) else $error("result sent before rate reduction");

endmodule

>>> hdl/h264_sps_header_parser.sv
// ----------------------------------------------------------------------------
// h264_sps_header_parser
// Parses one H.264 SPS payload into ids, profile fields, cropped size and
// reduced frame rate.
// ----------------------------------------------------------------------------
// Each byte is accepted, then goes through eight bit steps of the parser;
// no new byte is taken meanwhile. After the last byte: its bit steps, the
// calc step, the gcd and, when the gcd is nonzero, the divide, then the result
// register loads once the output is free.
// Synchronous reset clears the parser and empties the result register.
module h264_sps_header_parser
  import hsps_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  hsps_in_if.sink      bytes,
  hsps_out_if.source   results
);

  hsps_cmd_t    cmd;
  hsps_result_t result;
  logic         rate_start, rate_done;
  logic [32:0]  rate_num, rate_den, quot_den;
  logic [31:0]  quot_num;

  hsps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (bytes.valid),
    .in_last    (bytes.last_byte),
    .in_ready   (bytes.ready),
    .out_ready  (results.ready),
    .out_valid  (results.valid),
    .rate_done  (rate_done),
    .rate_start (rate_start),
    .cmd        (cmd)
  );

  hsps_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (bytes.data_byte),
    .quot_num  (quot_num),
    .quot_den  (quot_den),
    .rate_num  (rate_num),
    .rate_den  (rate_den),
    .result    (result)
  );

  hsps_rate u_rate (
    .clk      (clk),
    .rst      (rst),
    .start    (rate_start),
    .num      (rate_num),
    .den      (rate_den),
    .done     (rate_done),
    .quot_num (quot_num),
    .quot_den (quot_den)
  );

  assign results.set_id                = result.set_id;
  assign results.profile               = result.profile;
  assign results.level                 = result.level;
  assign results.chroma_format         = result.chroma_format;
  assign results.frame_only            = result.frame_only;
  assign results.order_count_type      = result.order_count_type;
  assign results.frame_num_bits_minus4 = result.frame_num_bits_minus4;
  assign results.picture_width         = result.picture_width;
  assign results.picture_height        = result.picture_height;
  assign results.rate_numerator        = result.rate_numerator;
  assign results.rate_denominator      = result.rate_denominator;
  assign results.status                = result.status;

endmodule

>>> tb/sv/h264_sps_header_parser_test.sv
// ----------------------------------------------------------------------------
// h264_sps_header_parser_test
// Sends SPS payloads built bit by bit (baseline and high profiles, scaling
// lists, order count branches, cropping, VUI with timing) plus bad codes,
// truncated and noise payloads through the byte channel. A bit-serial
// predictor decodes each accepted byte and queues the expected summary,
// which is compared field by field with every accepted result.
// ----------------------------------------------------------------------------
module h264_sps_header_parser_test;
  import hsps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BYTE_GOAL = 1450;
  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst;

  hsps_in_if  in_ch ();
  hsps_out_if out_ch ();

  h264_sps_header_parser u_top (
    .clk     (clk),
    .rst     (rst),
    .bytes   (in_ch.sink),
    .results (out_ch.source)
  );

  // parser copy
  logic [63:0] win;
  int unsigned avail, zcnt, loops, lidx, last_sc, next_sc;
  logic [31:0] crop [4];
  logic [31:0] prof, lvl, sid, chroma, wmb, hmb, ticks, tscale;
  logic [2:0]  flags;
  logic [1:0]  poc;
  logic [3:0]  fnum;
  logic [5:0]  step;

  hsps_result_t expected_summaries [$];
  bit stream_bits [$];
  int errors = 0;
  int bytes_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic clear_parser();
    win = '0; avail = 0; zcnt = 0; loops = 0; lidx = 0; last_sc = 8; next_sc = 8;
    for (int i = 0; i < 4; i++) crop[i] = '0;
    prof = '0; lvl = '0; sid = '0; chroma = '0; wmb = '0; hmb = '0;
    ticks = '0; tscale = '0; flags = '0; poc = '0; fnum = '0;
    step = S_PROFILE;
  endtask

  function automatic int step_len(input logic [5:0] s);
    case (s)
      S_PROFILE, S_CONSTRAINT, S_LEVEL, S_AR_IDC, S_PRIMARIES, S_TRANSFER,
      S_MATRIX: return 8;
      S_SAR_W, S_SAR_H: return 16;
      S_TICK, S_SCALE: return 32;
      S_VIDEO_FMT: return 3;
      S_SPS_ID, S_CHROMA, S_DEPTH_LUMA, S_DEPTH_CHROMA, S_LIST_DELTA, S_FRAME_NUM,
      S_POC_TYPE, S_POC_LSB, S_OFF_NONREF, S_OFF_TB, S_CYCLE_N, S_CYCLE_OFF,
      S_NUM_REF, S_WIDTH, S_HEIGHT, S_CROP, S_LOC_TOP, S_LOC_BOT: return 0;
      default: return 1;
    endcase
  endfunction

  task automatic advance_list();
    lidx++;
    step = (lidx >= 8) ? S_FRAME_NUM : S_LIST_FLAG;
  endtask

  task automatic take_field(input logic [31:0] v);
    case (step)
      S_PROFILE: begin prof = v; chroma = 1; step = S_CONSTRAINT; end
      S_CONSTRAINT: step = S_LEVEL;
      S_LEVEL: begin lvl = v; step = S_SPS_ID; end
      S_SPS_ID: begin
        if (v > 31) step = S_ERROR;
        else begin
          sid = v;
          step = (prof == 100 || prof == 110 || prof == 122 || prof == 144) ?
                 S_CHROMA : S_FRAME_NUM;
        end
      end
      S_CHROMA: begin
        if (v > 3) step = S_ERROR;
        else begin chroma = v; step = (v == 3) ? S_SEP_PLANE : S_DEPTH_LUMA; end
      end
      S_SEP_PLANE: step = S_DEPTH_LUMA;
      S_DEPTH_LUMA: step = S_DEPTH_CHROMA;
      S_DEPTH_CHROMA: step = S_BYPASS;
      S_BYPASS: step = S_MATRIX_FLAG;
      S_MATRIX_FLAG: begin lidx = 0; step = v ? S_LIST_FLAG : S_FRAME_NUM; end
      S_LIST_FLAG: begin
        if (v != 0) begin
          loops = 0; last_sc = 8; next_sc = 8; step = S_LIST_DELTA;
        end else advance_list();
      end
      S_LIST_DELTA: begin
        next_sc = (last_sc + v) & 255;
        if (next_sc != 0) last_sc = next_sc;
        loops++;
        if (next_sc == 0 || loops >= ((lidx < 6) ? 16 : 64)) advance_list();
      end
      S_FRAME_NUM: begin
        if (v > 12) step = S_ERROR;
        else begin fnum = v[3:0]; step = S_POC_TYPE; end
      end
      S_POC_TYPE: begin
        if (v > 2) step = S_ERROR;
        else begin
          poc = v[1:0];
          step = (v == 0) ? S_POC_LSB : (v == 1) ? S_DELTA_ZERO : S_NUM_REF;
        end
      end
      S_POC_LSB: step = S_NUM_REF;
      S_DELTA_ZERO: step = S_OFF_NONREF;
      S_OFF_NONREF: step = S_OFF_TB;
      S_OFF_TB: step = S_CYCLE_N;
      S_CYCLE_N: begin
        if (v > 255) step = S_ERROR;
        else begin loops = v; step = (v != 0) ? S_CYCLE_OFF : S_NUM_REF; end
      end
      S_CYCLE_OFF: begin
        if (loops > 0) loops--;
        if (loops == 0) step = S_NUM_REF;
      end
      S_NUM_REF: step = S_GAPS;
      S_GAPS: step = S_WIDTH;
      S_WIDTH: begin wmb = v; step = S_HEIGHT; end
      S_HEIGHT: begin hmb = v; step = S_FRAME_ONLY; end
      S_FRAME_ONLY: begin
        if (v != 0) flags[0] = 1'b1;
        step = v ? S_DIRECT : S_MBAFF;
      end
      S_MBAFF: step = S_DIRECT;
      S_DIRECT: step = S_CROP_FLAG;
      S_CROP_FLAG: begin
        if (v != 0) begin flags[1] = 1'b1; loops = 0; step = S_CROP; end
        else step = S_VUI;
      end
      S_CROP: begin
        crop[loops & 3] = v;
        loops++;
        if (loops >= 4) step = S_VUI;
      end
      S_VUI: step = v ? S_AR_FLAG : S_DONE;
      S_AR_FLAG: step = v ? S_AR_IDC : S_OVERSCAN;
      S_AR_IDC: step = (v == 255) ? S_SAR_W : S_OVERSCAN;
      S_SAR_W: step = S_SAR_H;
      S_SAR_H: step = S_OVERSCAN;
      S_OVERSCAN: step = v ? S_OVERSCAN_APP : S_VIDEO_SIG;
      S_OVERSCAN_APP: step = S_VIDEO_SIG;
      S_VIDEO_SIG: step = v ? S_VIDEO_FMT : S_CHROMA_LOC;
      S_VIDEO_FMT: step = S_FULL_RANGE;
      S_FULL_RANGE: step = S_COLOUR_DESC;
      S_COLOUR_DESC: step = v ? S_PRIMARIES : S_CHROMA_LOC;
      S_PRIMARIES: step = S_TRANSFER;
      S_TRANSFER: step = S_MATRIX;
      S_MATRIX: step = S_CHROMA_LOC;
      S_CHROMA_LOC: step = v ? S_LOC_TOP : S_TIMING;
      S_LOC_TOP: step = S_LOC_BOT;
      S_LOC_BOT: step = S_TIMING;
      S_TIMING: begin
        if (v != 0) flags[2] = 1'b1;
        step = v ? S_TICK : S_DONE;
      end
      S_TICK: begin ticks = v; step = S_SCALE; end
      S_SCALE: begin tscale = v; step = S_FIXED; end
      S_FIXED: step = S_DONE;
      default: step = S_ERROR;
    endcase
  endtask

  task automatic deliver(input logic [63:0] code);
    logic [31:0] v;
    v = code[31:0];
    win = '0; avail = 0; zcnt = 0;
    if (step == S_LIST_DELTA || step == S_OFF_NONREF || step == S_OFF_TB ||
        step == S_CYCLE_OFF) begin
      v = code[0] ? 32'((code + 1) >> 1) : 32'(0) - 32'(code >> 1);
    end
    take_field(v);
  endtask

  task automatic decode_bit(input bit b);
    int len;
    if (step >= S_DONE) return;
    len = step_len(step);
    if (len != 0) begin
      win = {win[62:0], b};
      avail++;
      if (avail >= len) deliver(win);
      return;
    end
    if (win == 0) begin
      if (!b) begin
        zcnt++;
        if (zcnt >= GOLOMB_MAX_BITS) step = S_ERROR;
        return;
      end
      win = 64'd1;
      avail = 0;
      if (zcnt == 0) deliver(64'd0);
      return;
    end
    win = {win[62:0], b};
    avail++;
    if (avail >= zcnt) deliver(win - 1);
  endtask

  task automatic summarize_sps();
    hsps_result_t r;
    longint w, h;
    longint unsigned num, den, x, y, t;
    int ux, uy, fo;
    r = '0;
    if (step != S_DONE) begin
      r.status = STATUS_BAD;
    end else begin
      fo = flags[0];
      w = (longint'(wmb) + 1) * 16;
      h = longint'(2 - fo) * (longint'(hmb) + 1) * 16;
      if (flags[1]) begin
        ux = (chroma == 1 || chroma == 2) ? 2 : 1;
        uy = (chroma == 1) ? 2 * (2 - fo) : (2 - fo);
        w -= longint'(ux) * (longint'(crop[0]) + longint'(crop[1]));
        h -= longint'(uy) * (longint'(crop[2]) + longint'(crop[3]));
      end
      r.set_id = sid[4:0];
      r.profile = prof[7:0];
      r.level = lvl[7:0];
      r.chroma_format = chroma[1:0];
      r.frame_only = flags[0];
      r.order_count_type = poc;
      r.frame_num_bits_minus4 = fnum;
      r.picture_width = (w < 0) ? 16'd0 : (w > 65535) ? 16'hFFFF : 16'(w);
      r.picture_height = (h < 0) ? 16'd0 : (h > 65535) ? 16'hFFFF : 16'(h);
      if (flags[2]) begin
        num = tscale;
        den = longint'(ticks) * 2;
        x = num; y = den;
        while (y != 0) begin t = x % y; x = y; y = t; end
        if (x != 0) begin num = num / x; den = den / x; end
        r.rate_numerator = num[31:0];
        r.rate_denominator = den[32:0];
        r.status = STATUS_OK;
      end else r.status = STATUS_NO_TIMING;
    end
    expected_summaries.push_back(r);
    clear_parser();
  endtask

  // sender
  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    bytes_sent++;
    for (int i = 7; i >= 0; i--) decode_bit(b[i]);
    if (last) summarize_sps();
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_summaries.size() != 0) @(posedge clk);
  endtask

  // bit stream builder
  task automatic put(input longint unsigned v, input int n);
    for (int i = n - 1; i >= 0; i--) stream_bits.push_back(v[i]);
  endtask

  task automatic put_ue(input longint unsigned v);
    longint unsigned code;
    int n;
    code = v + 1;
    n = 0;
    while ((code >> (n + 1)) != 0) n++;
    put(0, n);
    put(code, n + 1);
  endtask

  task automatic put_se(input longint v);
    put_ue((v > 0) ? longint'(2 * v - 1) : longint'(-2 * v));
  endtask

  function automatic longint unsigned pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return longint'($urandom % 32'hFFFF_FFFF);
    if (r == 1) return $urandom_range(0, 5000);
    return $urandom_range(0, 120);
  endfunction

  task automatic send_stream(input int cut_bytes);
    int nbytes;
    logic [7:0] b;
    while (stream_bits.size() % 8 != 0) stream_bits.push_back($urandom_range(0, 1));
    nbytes = stream_bits.size() / 8;
    if (cut_bytes > 0 && cut_bytes < nbytes) nbytes = cut_bytes;
    for (int i = 0; i < nbytes; i++) begin
      for (int k = 0; k < 8; k++) b[7 - k] = stream_bits[i * 8 + k];
      send_byte(b, i == nbytes - 1);
    end
    stream_bits.delete();
  endtask

  task automatic build_sps(input bit allow_bad);
    int prof_v, n, last, nxt, d, sz;
    bit hi;
    stream_bits.delete();
    case ($urandom_range(0, 7))
      0: prof_v = 66;
      1: prof_v = 77;
      2: prof_v = 88;
      3: prof_v = 100;
      4: prof_v = 110;
      5: prof_v = 122;
      6: prof_v = 144;
      default: prof_v = $urandom_range(0, 255);
    endcase
    hi = (prof_v == 100 || prof_v == 110 || prof_v == 122 || prof_v == 144);
    put(prof_v, 8);
    put($urandom, 8);
    put($urandom, 8);
    if (allow_bad && $urandom_range(0, 49) == 0) put(0, $urandom_range(32, 40));
    put_ue((allow_bad && $urandom_range(0, 39) == 0) ? $urandom_range(32, 300)
                                                     : $urandom_range(0, 31));
    if (hi) begin
      n = (allow_bad && $urandom_range(0, 39) == 0) ? $urandom_range(4, 9)
                                                    : $urandom_range(0, 3);
      put_ue(n);
      if (n == 3) put($urandom, 1);
      put_ue($urandom_range(0, 6));
      put_ue($urandom_range(0, 6));
      put($urandom, 1);
      if ($urandom_range(0, 1)) begin
        put(1, 1);
        for (int j = 0; j < 8; j++) begin
          if ($urandom_range(0, 2) == 0) begin
            put(0, 1);
            continue;
          end
          put(1, 1);
          sz = (j < 6) ? 16 : 64;
          last = 8;
          for (int k = 0; k < sz; k++) begin
            if ($urandom_range(0, 5) == 0) d = (256 - last) & 255;
            else d = $urandom_range(0, 255);
            if (d > 127) d -= 256;
            put_se(d);
            nxt = (last + d) & 255;
            if (nxt == 0) break;
            last = nxt;
          end
        end
      end else put(0, 1);
    end
    put_ue((allow_bad && $urandom_range(0, 39) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(0, 12));
    n = (allow_bad && $urandom_range(0, 39) == 0) ? $urandom_range(3, 5)
                                                  : $urandom_range(0, 2);
    put_ue(n);
    if (n == 0) put_ue($urandom_range(0, 12));
    if (n == 1) begin
      put($urandom, 1);
      put_se(int'($urandom_range(0, 2000)) - 1000);
      put_se(int'($urandom_range(0, 2000)) - 1000);
      case ($urandom_range(0, 19))
        0: n = 255;
        1: n = allow_bad ? 256 : 0;
        default: n = $urandom_range(0, 4);
      endcase
      put_ue(n);
      for (int k = 0; k < n && k < 256; k++) put_se(int'($urandom_range(0, 64)) - 32);
    end
    put_ue($urandom_range(0, 16));
    put($urandom, 1);
    put_ue(pick_size());
    put_ue(pick_size());
    n = $urandom_range(0, 1);
    put(n, 1);
    if (n == 0) put($urandom, 1);
    put($urandom, 1);
    if ($urandom_range(0, 1)) begin
      put(1, 1);
      for (int k = 0; k < 4; k++)
        put_ue(($urandom_range(0, 9) == 0) ? pick_size() : $urandom_range(0, 20));
    end else put(0, 1);
    if ($urandom_range(0, 3) != 0) begin
      put(1, 1);
      if ($urandom_range(0, 1)) begin
        put(1, 1);
        n = $urandom_range(0, 1) ? 255 : $urandom_range(0, 255);
        put(n, 8);
        if (n == 255) put($urandom, 32);
      end else put(0, 1);
      n = $urandom_range(0, 1);
      put(n, 1);
      if (n) put($urandom, 1);
      if ($urandom_range(0, 1)) begin
        put(1, 1);
        put($urandom, 4);
        if ($urandom_range(0, 1)) begin
          put(1, 1);
          put($urandom, 24);
        end else put(0, 1);
      end else put(0, 1);
      if ($urandom_range(0, 1)) begin
        put(1, 1);
        put_ue($urandom_range(0, 5));
        put_ue($urandom_range(0, 5));
      end else put(0, 1);
      if ($urandom_range(0, 4) != 0) begin
        put(1, 1);
        case ($urandom_range(0, 5))
          0: put(0, 64);
          1: begin put(0, 32); put($urandom, 32); end
          2: begin put($urandom, 32); put(0, 32); end
          3: begin put(1001, 32); put(60000, 32); end
          4: begin put(32'hFFFF_FFFF, 32); put(32'hFFFF_FFFF, 32); end
          default: begin put($urandom, 32); put($urandom, 32); end
        endcase
        put($urandom, 1);
      end else put(0, 1);
    end else put(0, 1);
    put(1, 1);
    repeat ($urandom_range(0, 2)) put($urandom, 8);
  endtask

  // tests
  task automatic test_baseline_extremes();
    // smallest baseline SPS, no VUI
    put(66, 8); put(8'hFF, 8); put(0, 8); put_ue(0); put_ue(0); put_ue(2);
    put_ue(0); put(0, 1); put_ue(0); put_ue(0); put(1, 1); put(0, 1); put(0, 1); put(0, 1);
    send_stream(0);
    // largest ids and ue at the longest legal prefix
    put(255, 8); put(0, 8); put(255, 8); put_ue(31); put_ue(12); put_ue(2);
    put_ue(0); put(1, 1); put_ue(32'hFFFF_FFFE); put_ue(0); put(0, 1); put(0, 1);
    put(0, 1); put(0, 1); put(0, 1);
    send_stream(0);
  endtask

  task automatic test_bad_codes();
    put(77, 8); put(0, 8); put(30, 8); put(0, 32); put(1, 8);
    send_stream(0);
    send_byte(8'h42, 1'b1);
  endtask

  task automatic test_truncation();
    build_sps(1'b0);
    send_stream(2);
  endtask

  task automatic test_random_streams();
    int r;
    while (bytes_sent < BYTE_GOAL) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        repeat ($urandom_range(0, 12)) send_byte($urandom, 1'b0);
        send_byte($urandom, 1'b1);
      end else begin
        build_sps(1'b1);
        send_stream((r == 1) ? $urandom_range(1, 8) : 0);
      end
    end
  endtask

  // result checker and receiver stalls
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    hsps_result_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_summaries.size() == 0) begin
          errors++;
          $display("UNEXPECTED result at %0t", $realtime);
        end else begin
          e = expected_summaries.pop_front();
          if (out_ch.set_id !== e.set_id) report("set_id", out_ch.set_id, e.set_id);
          if (out_ch.profile !== e.profile) report("profile", out_ch.profile, e.profile);
          if (out_ch.level !== e.level) report("level", out_ch.level, e.level);
          if (out_ch.chroma_format !== e.chroma_format)
            report("chroma_format", out_ch.chroma_format, e.chroma_format);
          if (out_ch.frame_only !== e.frame_only)
            report("frame_only", out_ch.frame_only, e.frame_only);
          if (out_ch.order_count_type !== e.order_count_type)
            report("order_count_type", out_ch.order_count_type, e.order_count_type);
          if (out_ch.frame_num_bits_minus4 !== e.frame_num_bits_minus4)
            report("frame_num_bits_minus4", out_ch.frame_num_bits_minus4,
                   e.frame_num_bits_minus4);
          if (out_ch.picture_width !== e.picture_width)
            report("picture_width", out_ch.picture_width, e.picture_width);
          if (out_ch.picture_height !== e.picture_height)
            report("picture_height", out_ch.picture_height, e.picture_height);
          if (out_ch.rate_numerator !== e.rate_numerator)
            report("rate_numerator", out_ch.rate_numerator, e.rate_numerator);
          if (out_ch.rate_denominator !== e.rate_denominator)
            report("rate_denominator", out_ch.rate_denominator, e.rate_denominator);
          if (out_ch.status !== e.status) report("status", out_ch.status, e.status);
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 100);
      end else stall_left--;
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    clear_parser();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_baseline_extremes();
    test_bad_codes();
    test_truncation();
    wait_for_results();
    test_random_streams();
    wait_for_results();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> h264_sps_header_parser.f
hdl/hsps_pkg.sv
hdl/hsps_in_if.sv
hdl/hsps_out_if.sv
hdl/hsps_rate.sv
hdl/hsps_datapath.sv
hdl/hsps_ctrl.sv
hdl/h264_sps_header_parser.sv
tb/sv/h264_sps_header_parser_test.sv
